>>> rtl/mdrc_pkg.sv
// mdrc_pkg: shared types and constants for the magnetic detumble rate controller
// no dependencies; imported by the top level, the divider and the checker
`default_nettype none

package mdrc_pkg;

  // gain register, unsigned q16.16
  localparam int unsigned GAIN_W      = 32;
  localparam int unsigned GAIN_FRAC_W = 16;

  // moment limit register
  localparam int unsigned LIMIT_W = 15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7fff;

  // configuration channel
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned NUM_AXES = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_GAIN  = 8'd0,
    REG_MAX_MOMENT = 8'd1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GAIN_GO,
    ST_GAIN_WAIT,
    ST_MAG,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_SUM1,
    ST_SUM2,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_CMP,
    ST_SCL_GO,
    ST_SCL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN,
    ST_DONE
  } mdrc_state_e;

endpackage

`default_nettype wire

>>> rtl/mdrc_sermul.sv
// mdrc_sermul: bit-serial shift-add multiplier, multiplier operand consumed msb first
// no package dependency; instantiated once per axis by the top level
`default_nettype none

module mdrc_sermul #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 33,
  localparam int unsigned P_W   = A_W + B_W,
  localparam int unsigned CNT_W = $clog2(B_W + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CNT_W-1:0] len_i,   // number of multiplier bits to consume
  input  wire logic [A_W-1:0]   a_i,
  input  wire logic [B_W-1:0]   b_i,     // left aligned, top len_i bits are used
  output logic                  busy_o,
  output logic [P_W-1:0]        prod_o
);

  logic [A_W-1:0]   a_q;
  logic [B_W-1:0]   b_q, b_d;
  logic [P_W-1:0]   p_q, p_d;
  logic [CNT_W-1:0] cnt_q;

  // product doubles and picks up the multiplicand for each set bit
  assign p_d = {p_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
  assign b_d = {b_q[B_W-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= len_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (cnt_q != '0) begin
      b_q <= b_d;
      p_q <= p_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = p_q;

endmodule

`default_nettype wire

>>> rtl/mdrc_sqrt.sv
// mdrc_sqrt: digit-serial floor square root, one root bit per cycle
// no package dependency; instantiated by the top level
`default_nettype none

module mdrc_sqrt #(
  parameter int unsigned ROOT_W = 34,
  localparam int unsigned RAD_W = 2 * ROOT_W,
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  output logic                   busy_o,
  output logic [ROOT_W-1:0]      root_o
);

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [ROOT_W+2:0] cur, trial, diff;
  logic              ge;

  // remainder takes the next two radicand bits, trial is 4r+1
  always_comb begin
    cur    = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = cur - trial;
    ge     = (cur >= trial);
    rem_d  = ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
    root_d = {root_q[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(ROOT_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> rtl/mdrc_div.sv
// mdrc_div: restoring divider, one quotient bit per cycle, quotient of limit width
// depends on mdrc_pkg; the caller guarantees the quotient fits LIMIT_W bits
`default_nettype none

module mdrc_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 34
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [NUM_W-1:0]              num_i,
  input  wire logic [DEN_W-1:0]              den_i,
  output logic                               busy_o,
  output logic [mdrc_pkg::LIMIT_W-1:0]       quot_o
);

  import mdrc_pkg::*;

  localparam int unsigned CNT_W = $clog2(LIMIT_W + 1);

  logic [DEN_W-1:0]   rem_q, rem_d, den_q;
  logic [LIMIT_W-1:0] nlo_q, q_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEN_W:0]     cur, diff;
  logic               ge;

  always_comb begin
    cur   = {rem_q, nlo_q[LIMIT_W-1]};
    diff  = cur - {1'b0, den_q};
    ge    = (cur >= {1'b0, den_q});
    rem_d = ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(LIMIT_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // upper numerator bits already lie below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_W'(num_i[NUM_W-1:LIMIT_W]);
      nlo_q <= num_i[LIMIT_W-1:0];
      den_q <= den_i;
      q_q   <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      nlo_q <= {nlo_q[LIMIT_W-2:0], 1'b0};
      q_q   <= {q_q[LIMIT_W-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = q_q;

endmodule

`default_nettype wire

>>> rtl/magnetic_detumble_rate_controller_unit.sv
// magnetic_detumble_rate_controller_unit: b-dot detumble law with vector magnitude limit
// depends on mdrc_pkg, mdrc_sermul, mdrc_sqrt and mdrc_div
//
// usage
//   s_axis carries one magnetometer sample per transaction, m_axis one moment
//   vector per accepted sample, in the same order. the cfg channel writes the
//   gain (index 0) and the magnitude limit (index 1); it is always ready. the
//   user must write it only while no sample is in flight; the block itself does
//   not enforce this. one sample at a time: s_axis_tready_o is high only while
//   the sequencer idles, so the next sample can be accepted in the cycle after
//   the hand-over to the output. with a zero gain or an unprimed sample the answer
//   is zeros, loaded into the output register from the hand-over state, which the
//   sequencer enters straight from idle. otherwise the three axes run in lanes
//   through bit-serial multipliers (gain times difference, then squares), a
//   shared digit-serial square root and, when the limit engages, a bit-serial
//   scale and a 15-step divide per axis. the output register parts the two
//   sides: a stalled receiver holds the result while the next sample is accepted
//   and processed; the new result waits in the sequencer until the output
//   register is free. reset clears the stored sample flag, sets the gain to zero
//   and the limit to its maximum, empties the output.
`default_nettype none

module magnetic_detumble_rate_controller_unit #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MOMENT_BITS = 16,
  localparam int unsigned IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * MOMENT_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input stream
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [IN_W-1:0]                    s_axis_tdata_i,  // field_x, field_y, field_z
  // output stream
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output logic [OUT_W-1:0]                        m_axis_tdata_o,  // moment_x, moment_y, moment_z
  // configuration writes
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [mdrc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mdrc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import mdrc_pkg::*;

  // widths of the datapath
  localparam int unsigned DIFF_W    = SAMPLE_BITS + 1;             // field difference
  localparam int unsigned GP_W      = GAIN_W + DIFF_W;             // gain product
  localparam int unsigned MAG_W     = GP_W - GAIN_FRAC_W;          // |m| before limiting
  localparam int unsigned MUL_A_W   = (GAIN_W > MAG_W) ? GAIN_W : MAG_W;
  localparam int unsigned MUL_B_W   = MAG_W;                       // covers diff and limit too
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W + 1);
  localparam int unsigned SQ_W      = 2 * MAG_W;
  localparam int unsigned ROOT_W    = MAG_W + 1;
  localparam int unsigned SUM_W     = 2 * ROOT_W;
  localparam int unsigned NUM_W     = MAG_W + LIMIT_W;
  localparam logic [MAG_W-1:0] MOM_MAX =
    MAG_W'((64'd1 << (MOMENT_BITS - 1)) - 64'd1);

  mdrc_state_e state_q, state_d;

  // configuration and stored state
  logic [GAIN_W-1:0]      rate_gain_q;
  logic [LIMIT_W-1:0]     max_moment_q;
  logic                   primed_q;
  logic [SAMPLE_BITS-1:0] last_q [NUM_AXES];

  // per-axis lanes
  logic [SAMPLE_BITS-1:0] field_in [NUM_AXES];
  logic [DIFF_W-1:0]      diff_in  [NUM_AXES];
  logic [DIFF_W-1:0]      dmag_q   [NUM_AXES];
  logic                   dneg_q   [NUM_AXES];
  logic [MAG_W-1:0]       mag_q    [NUM_AXES];
  logic [MAG_W-1:0]       mag_d    [NUM_AXES];
  logic                   mneg_q   [NUM_AXES];
  logic [MOMENT_BITS-1:0] res_q    [NUM_AXES];
  logic [MOMENT_BITS-1:0] res_d    [NUM_AXES];

  logic [MUL_A_W-1:0]     mul_a    [NUM_AXES];
  logic [MUL_B_W-1:0]     mul_b    [NUM_AXES];
  logic [MUL_P_W-1:0]     mul_p    [NUM_AXES];
  logic [MUL_CNT_W-1:0]   mul_len;
  logic                   mul_start;
  logic [NUM_AXES-1:0]    mul_busy;

  logic [LIMIT_W-1:0]     quot     [NUM_AXES];
  logic                   div_start;
  logic [NUM_AXES-1:0]    div_busy;

  logic [SUM_W-1:0]       sum_q;
  logic [ROOT_W-1:0]      root;
  logic                   sqrt_start, sqrt_busy;
  logic                   scaled_q;

  logic                   m_valid_q, m_valid_d;
  logic [OUT_W-1:0]       m_data_q, m_data_d;
  logic                   s_accept, out_load, work_path;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  // a sample goes through the datapath only with a nonzero gain and a stored sample
  assign work_path       = (rate_gain_q != '0) && primed_q;

  // unpack the sample and form the per-axis difference
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      field_in[i] = s_axis_tdata_i[i*SAMPLE_BITS +: SAMPLE_BITS];
      diff_in[i]  = {field_in[i][SAMPLE_BITS-1], field_in[i]}
                  - {last_q[i][SAMPLE_BITS-1], last_q[i]};
    end
  end

  // operands for the serial multipliers, chosen by the phase that starts them
  always_comb begin
    mul_len = MUL_CNT_W'(LIMIT_W);
    for (int i = 0; i < NUM_AXES; i++) begin
      mul_a[i] = MUL_A_W'(mag_q[i]);
      mul_b[i] = {max_moment_q, {(MUL_B_W - LIMIT_W){1'b0}}};
    end
    case (state_q)
      ST_GAIN_GO: begin
        mul_len = MUL_CNT_W'(DIFF_W);
        for (int i = 0; i < NUM_AXES; i++) begin
          mul_a[i] = MUL_A_W'(rate_gain_q);
          mul_b[i] = {dmag_q[i], {(MUL_B_W - DIFF_W){1'b0}}};
        end
      end
      ST_SQ_GO: begin
        mul_len = MUL_CNT_W'(MAG_W);
        for (int i = 0; i < NUM_AXES; i++) begin
          mul_b[i] = mag_q[i];
        end
      end
      default: begin
      end
    endcase
  end

  // |m| from the gain product: floor of the negated product, so a positive
  // difference rounds its magnitude up
  always_comb begin
    logic [GP_W:0] rnd;
    rnd = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      rnd = {1'b0, mul_p[i][GP_W-1:0]} + (GP_W + 1)'({GAIN_FRAC_W{1'b1}});
      if (dneg_q[i]) begin
        mag_d[i] = mul_p[i][GP_W-1:GAIN_FRAC_W];
      end else begin
        mag_d[i] = rnd[GP_W-1:GAIN_FRAC_W];
      end
    end
  end

  // final magnitude, clamp to the symmetric output range and restore the sign
  always_comb begin
    logic [MAG_W-1:0]       fin_mag;
    logic [MOMENT_BITS-1:0] sat_lo;
    fin_mag = '0;
    sat_lo  = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      fin_mag  = scaled_q ? MAG_W'(quot[i]) : mag_q[i];
      sat_lo   = (fin_mag > MOM_MAX) ? MOM_MAX[MOMENT_BITS-1:0] : fin_mag[MOMENT_BITS-1:0];
      res_d[i] = mneg_q[i] ? (~sat_lo + 1'b1) : sat_lo;
    end
  end

  // output packing, padding bits stay zero
  always_comb begin
    m_data_d = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      m_data_d[i*MOMENT_BITS +: MOMENT_BITS] = res_q[i];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = work_path ? ST_GAIN_GO : ST_DONE;
        end
      end
      ST_GAIN_GO: begin
        mul_start = 1'b1;
        state_d   = ST_GAIN_WAIT;
      end
      ST_GAIN_WAIT: begin
        if (mul_busy == '0) begin
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        state_d = ST_SQ_GO;
      end
      ST_SQ_GO: begin
        mul_start = 1'b1;
        state_d   = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_busy == '0) begin
          state_d = ST_SUM1;
        end
      end
      ST_SUM1: begin
        state_d = ST_SUM2;
      end
      ST_SUM2: begin
        state_d = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (!sqrt_busy) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = (root > ROOT_W'(max_moment_q)) ? ST_SCL_GO : ST_FIN;
      end
      ST_SCL_GO: begin
        mul_start = 1'b1;
        state_d   = ST_SCL_WAIT;
      end
      ST_SCL_WAIT: begin
        if (mul_busy == '0) begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_busy == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hand over once the output register is empty or being emptied
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration registers and the primed flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_gain_q  <= '0;
      max_moment_q <= LIMIT_RESET;
      primed_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_RATE_GAIN:  rate_gain_q  <= cfg_data_i[GAIN_W-1:0];
          REG_MAX_MOMENT: max_moment_q <= cfg_data_i[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (s_accept && (rate_gain_q != '0)) begin
        primed_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (rate_gain_q != '0) begin
          last_q[i] <= field_in[i];
        end
        dneg_q[i] <= diff_in[i][DIFF_W-1];
        dmag_q[i] <= diff_in[i][DIFF_W-1] ? (~diff_in[i] + 1'b1) : diff_in[i];
        // zeros answer the priming sample and a zero gain
        if (!work_path) begin
          res_q[i] <= '0;
        end
      end
    end
    case (state_q)
      ST_MAG: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          mag_q[i]  <= mag_d[i];
          mneg_q[i] <= !dneg_q[i] && (dmag_q[i] != '0);
        end
      end
      ST_SUM1: begin
        sum_q <= SUM_W'(mul_p[0][SQ_W-1:0]) + SUM_W'(mul_p[1][SQ_W-1:0]);
      end
      ST_SUM2: begin
        sum_q <= sum_q + SUM_W'(mul_p[2][SQ_W-1:0]);
      end
      ST_CMP: begin
        scaled_q <= (root > ROOT_W'(max_moment_q));
      end
      ST_FIN: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          res_q[i] <= res_d[i];
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  assign m_valid_d = out_load || (m_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // lanes: multiplier and divider per axis
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    mdrc_sermul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
    ) u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (mul_start),
      .len_i   (mul_len),
      .a_i     (mul_a[g]),
      .b_i     (mul_b[g]),
      .busy_o  (mul_busy[g]),
      .prod_o  (mul_p[g])
    );

    mdrc_div #(
      .NUM_W (NUM_W),
      .DEN_W (ROOT_W)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (mul_p[g][NUM_W-1:0]),
      .den_i   (root),
      .busy_o  (div_busy[g]),
      .quot_o  (quot[g])
    );
  end

  // shared root of the sum of squares
  mdrc_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sum_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

endmodule

`default_nettype wire

>>> rtl/mdrc_chk.sv
// mdrc_chk: port-level checks for the detumble controller, bound to the top level
// depends on mdrc_pkg and magnetic_detumble_rate_controller_unit
`default_nettype none

module mdrc_chk #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MOMENT_BITS = 16,
  localparam int unsigned IN_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * MOMENT_BITS + 7) / 8) * 8
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_o,
  input wire logic [IN_W-1:0]                 s_axis_tdata_i,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [OUT_W-1:0]                m_axis_tdata_o,
  input wire logic                            cfg_valid_i,
  input wire logic                            cfg_ready_o,
  input wire logic [mdrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [mdrc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import mdrc_pkg::*;

  localparam logic [MOMENT_BITS-1:0] MOST_NEG = {1'b1, {(MOMENT_BITS - 1){1'b0}}};

  logic in_xact;
  assign in_xact = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

  // one sample in flight at a time, and an accepted sample is fully known
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact |-> !$isunknown(s_axis_tdata_i) ##1 !s_axis_tready_o)
    else $error("input accepted while a sample was in flight, or with unknown data");

  // a new result only comes out of a busy sequencer
  a_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without a sample in flight");

  // moments are clamped symmetrically
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[0*MOMENT_BITS +: MOMENT_BITS] != MOST_NEG) &&
      (m_axis_tdata_o[1*MOMENT_BITS +: MOMENT_BITS] != MOST_NEG) &&
      (m_axis_tdata_o[2*MOMENT_BITS +: MOMENT_BITS] != MOST_NEG))
    else $error("moment outside the symmetric output range");

  // register writes land only while the sequencer idles, with known values
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> s_axis_tready_o && !$isunknown({cfg_index_i, cfg_data_i}))
    else $error("register write while a sample was in flight");

endmodule

bind magnetic_detumble_rate_controller_unit mdrc_chk #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .MOMENT_BITS (MOMENT_BITS)
) u_mdrc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .cfg_index_i     (cfg_index_i),
  .cfg_data_i      (cfg_data_i)
);

`default_nettype wire

>>> dv/testbench.sv
// testbench: self-checking bench for magnetic_detumble_rate_controller_unit
// drives magnetometer samples and register writes, predicts every moment vector
// and compares it field by field; depends on mdrc_pkg and the unit under test
`timescale 1ns / 1ps

module testbench;
  import mdrc_pkg::*;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MOMENT_W    = 16;
  localparam longint      MOMENT_PEAK = 32767;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          HOLD_CYCLES = 600;   // long receiver hold-off
  localparam int          TAIL_CYCLES = 200;   // beyond the worst latency
  localparam int          CHUNK_ITEMS = 40;
  localparam int          CHUNKS      = 11;
  localparam int          PRINT_CAP   = 40;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP      = 8'hff;

  // x in the lowest bits, as on the stream
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] z;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] x;
  } field_vec_t;

  typedef struct packed {
    logic signed [MOMENT_W-1:0] z;
    logic signed [MOMENT_W-1:0] y;
    logic signed [MOMENT_W-1:0] x;
  } moment_vec_t;

  typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    field_vec_t             field;
    bit                     zeros_due;  // answer known to be all zeros
  } stim_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [47:0]           s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [47:0]           m_axis_tdata_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  magnetic_detumble_rate_controller_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // b-dot predictor: own copy of the registers and the stored sample
  // ---------------------------------------------------------------------------
  logic [31:0]        gain_q;
  logic [LIMIT_W-1:0] limit_q;
  field_vec_t         last_field_q;
  bit                 primed_q;

  moment_vec_t pending_moments[$];
  int          mismatch_cnt = 0;
  int          result_cnt   = 0;
  int          cycle_cnt    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req_cnt  = 0;

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_RATE_GAIN) begin
      gain_q = data;
    end else if (idx == REG_MAX_MOMENT) begin
      limit_q = data[LIMIT_W-1:0];
    end
    // any other index is ignored
  endfunction

  // moment for one sample; stores the sample whenever the gain is nonzero
  function automatic moment_vec_t b_dot_moment(input field_vec_t f);
    longint      now_v[3];
    longint      old_v[3];
    longint      m[3];
    longint      prod;
    longint      mag;
    logic [127:0] sum_sq;
    logic [63:0]  root;
    logic [63:0]  trial;
    moment_vec_t  res;
    res = '0;
    // zero gain: zeros, nothing stored, priming left alone
    if (gain_q == 0) return res;
    // priming sample: store and answer zeros
    if (!primed_q) begin
      last_field_q = f;
      primed_q = 1'b1;
      return res;
    end
    now_v[0] = longint'(f.x);
    now_v[1] = longint'(f.y);
    now_v[2] = longint'(f.z);
    old_v[0] = longint'(last_field_q.x);
    old_v[1] = longint'(last_field_q.y);
    old_v[2] = longint'(last_field_q.z);
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      prod = longint'({32'd0, gain_q}) * (now_v[i] - old_v[i]);
      m[i] = (-prod) >>> 16;  // floor of the negated product
      mag = (m[i] < 0) ? -m[i] : m[i];
      sum_sq += {64'd0, mag} * {64'd0, mag};
    end
    root = '0;
    for (int b = 43; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if ({64'd0, trial} * {64'd0, trial} <= sum_sq) root = trial;
    end
    // magnitude limit, truncating toward zero
    if (root > {49'd0, limit_q}) begin
      for (int i = 0; i < 3; i++)
        m[i] = (m[i] * longint'({49'd0, limit_q})) / longint'(root);
    end
    for (int i = 0; i < 3; i++) begin
      if (m[i] > MOMENT_PEAK) m[i] = MOMENT_PEAK;
      if (m[i] < -MOMENT_PEAK) m[i] = -MOMENT_PEAK;
    end
    res.x = m[0][MOMENT_W-1:0];
    res.y = m[1][MOMENT_W-1:0];
    res.z = m[2][MOMENT_W-1:0];
    last_field_q = f;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // output side: ready pattern with an occasional long hold-off
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (hold_seen != hold_req_cnt) begin
      // hold off while the sender keeps offering, so the unit backs up
      hold_seen <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check against the oldest pending moment
  always @(posedge clk_i) begin
    moment_vec_t got;
    moment_vec_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_moments.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d/%0d", got.x, got.y, got.z));
      end else begin
        want = pending_moments.pop_front();
        if (got.x !== want.x)
          report_mismatch($sformatf("result %0d moment_x %0d, predicted %0d",
                                    result_cnt, got.x, want.x));
        if (got.y !== want.y)
          report_mismatch($sformatf("result %0d moment_y %0d, predicted %0d",
                                    result_cnt, got.y, want.y));
        if (got.z !== want.z)
          report_mismatch($sformatf("result %0d moment_z %0d, predicted %0d",
                                    result_cnt, got.z, want.z));
      end
      result_cnt++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               pending_moments.size());
      $display("** magnetic_detumble_rate_controller_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // register write, only once every pending moment has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid_i <= 1'b0;
    while (pending_moments.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg_write(idx, data);
  endtask

  // one sample transaction, valid held across back-to-back items
  task automatic send_field(input field_vec_t f, input bit zeros_due);
    moment_vec_t want;
    cfg_valid_i <= 1'b0;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= f;
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = b_dot_moment(f);
    if (zeros_due) want = '0;
    pending_moments.push_back(want);
  endtask

  function automatic stim_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    r.field = '0;
    r.zeros_due = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t row_field(input int x, input int y, input int z,
                                          input bit zeros_due);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.idx = '0;
    r.data = '0;
    r.field.x = x[SAMPLE_W-1:0];
    r.field.y = y[SAMPLE_W-1:0];
    r.field.z = z[SAMPLE_W-1:0];
    r.zeros_due = zeros_due;
    return r;
  endfunction

  // next value of one axis: mostly a slow drift, sometimes a jump or an extreme
  function automatic logic signed [SAMPLE_W-1:0] next_axis(input logic signed [SAMPLE_W-1:0] base);
    int v;
    int span;
    int pick;
    pick = $urandom_range(9);
    if (pick <= 5) begin
      span = 1 << $urandom_range(12);
      v = int'(base) + int'($urandom_range(2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else if (pick <= 7) begin
      v = int'($urandom_range(65535)) - 32768;
    end else if (pick == 8) begin
      case ($urandom_range(3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end else begin
      v = int'(base);
    end
    return v[SAMPLE_W-1:0];
  endfunction

  stim_row_t  stim_rows[$];
  field_vec_t last_sent;
  field_vec_t f;
  logic [31:0] gain_pick;
  int          limit_pick;

  initial begin
    gain_q = '0;
    limit_q = LIMIT_RESET;
    last_field_q = '0;
    primed_q = 1'b0;
    last_sent = '0;

    // directed rows: reset state, priming, extremes, limit corners, stray writes
    stim_rows.push_back(row_field(100, -200, 300, 1'b1));         // gain zero after reset
    stim_rows.push_back(row_field(-32768, 32767, 0, 1'b1));       // still not primed
    stim_rows.push_back(row_write(REG_RATE_GAIN, 32'h0001_0000));
    stim_rows.push_back(row_field(1000, 2000, -3000, 1'b1));      // priming sample
    stim_rows.push_back(row_field(1010, 1990, -3000, 1'b0));
    stim_rows.push_back(row_field(32767, 32767, 32767, 1'b0));    // limit at reset value
    stim_rows.push_back(row_field(-32768, -32768, -32768, 1'b0));
    stim_rows.push_back(row_write(REG_RATE_GAIN, 32'hffff_ffff));
    stim_rows.push_back(row_field(32767, -32768, 32767, 1'b0));   // largest steps
    stim_rows.push_back(row_field(-32768, 32767, -32768, 1'b0));
    stim_rows.push_back(row_write(REG_MAX_MOMENT, 32'd0));
    stim_rows.push_back(row_field(0, 0, 1, 1'b1));                // zero limit
    stim_rows.push_back(row_write(IDX_UNMAPPED, 32'h1234_5678));  // no register there
    stim_rows.push_back(row_write(IDX_TOP, 32'hffff_ffff));
    stim_rows.push_back(row_field(5, -7, 9, 1'b1));               // limit still zero
    stim_rows.push_back(row_write(REG_MAX_MOMENT, 32'hffff_8005)); // upper bits dropped
    stim_rows.push_back(row_write(REG_RATE_GAIN, 32'd1));
    stim_rows.push_back(row_field(6, -7, 9, 1'b0));               // floor of a tiny negative
    stim_rows.push_back(row_field(5, -7, 9, 1'b0));
    stim_rows.push_back(row_write(REG_RATE_GAIN, 32'd0));
    stim_rows.push_back(row_field(-1, -1, -1, 1'b1));             // zero gain, not stored
    stim_rows.push_back(row_write(REG_RATE_GAIN, 32'h0003_8000));
    stim_rows.push_back(row_write(REG_MAX_MOMENT, 32'h0000_7fff));
    stim_rows.push_back(row_field(-1, -1, -1, 1'b0));
    stim_rows.push_back(row_field(200, -300, 400, 1'b0));
    stim_rows.push_back(row_field(200, -300, 400, 1'b0));         // no change, zero moment

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct <= 81;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_field(stim_rows[i].field, stim_rows[i].zeros_due);
        last_sent = stim_rows[i].field;
      end
    end

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct <= 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct <= 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        case ($urandom_range(7))
          0: gain_pick = 32'd0;
          1: gain_pick = $urandom_range(1, 65535);
          2, 3: gain_pick = $urandom_range(65536, 1 << 20);
          4: gain_pick = 32'hffff_ffff;
          5: gain_pick = 32'h0001_0000;
          default: gain_pick = $urandom;
        endcase
        case ($urandom_range(5))
          0: limit_pick = 0;
          1: limit_pick = 32767;
          2: limit_pick = 1;
          default: limit_pick = $urandom_range(32767);
        endcase
        write_reg(REG_RATE_GAIN, gain_pick);
        write_reg(REG_MAX_MOMENT, ($urandom & 32'hffff_8000) | 32'(limit_pick));
        if ($urandom_range(3) == 0)
          write_reg(8'($urandom_range(2, 255)), $urandom);

        for (int n = 0; n < CHUNK_ITEMS; n++) begin
          // long receiver hold-off while samples keep coming
          if (chunk == 5 && n == 0) hold_req_cnt <= hold_req_cnt + 1;
          // sender pauses until the unit has drained
          if (phase == 2 && chunk == 3 && n == 20) begin
            s_axis_tvalid_i <= 1'b0;
            while (pending_moments.size() != 0) @(posedge clk_i);
          end
          f.x = next_axis(last_sent.x);
          f.y = next_axis(last_sent.y);
          f.z = next_axis(last_sent.z);
          send_field(f, 1'b0);
          last_sent = f;
        end
      end
    end

    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_moments.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_moments.size() == 0) begin
      $display("** magnetic_detumble_rate_controller_unit: PASSED **");
    end else begin
      $display("** magnetic_detumble_rate_controller_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mdrc_pkg.sv
rtl/mdrc_sermul.sv
rtl/mdrc_sqrt.sv
rtl/mdrc_div.sv
rtl/magnetic_detumble_rate_controller_unit.sv
rtl/mdrc_chk.sv
dv/testbench.sv
